// File: src/mqd_pkg.sv
// ----------------------------------------------------------------------------
// mqd_pkg: shared types and tables of the MQ arithmetic decoder
// Request record and operation codes, probability state tables, sizes.
// ----------------------------------------------------------------------------
package mqd_pkg;

   localparam int NUM_CONTEXTS = 32;
   localparam int CTX_W        = $clog2(NUM_CONTEXTS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QI_W         = $clog2(QUEUE_DEPTH);
   localparam int LABEL_W      = 5;

   localparam logic [5:0]  LAST_STATE    = 6'd46;
   localparam logic [15:0] INTERVAL_INIT = 16'h8000;
   localparam logic [7:0]  STUFF_BYTE    = 8'hFF;
   localparam logic [7:0]  MARKER_MIN    = 8'h8F;
   localparam logic [31:0] MARKER_ADD    = 32'h0000_FF00;
   localparam logic [3:0]  BITS_PLAIN    = 4'd8;
   localparam logic [3:0]  BITS_STUFFED  = 4'd7;
   localparam logic [4:0]  MAX_SHIFTS    = 5'd16;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_PUSH   = 2'd1,
      OP_START  = 2'd2,
      OP_DECODE = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LABEL_W-1:0]   label;
      logic [7:0]           byte_value;
      logic                 load_mps;
      logic [5:0]           load_state;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   localparam logic [15:0] QE_TAB [47] = '{
      16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
      16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
      16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
      16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
      16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
      16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};

   localparam logic [5:0] MPS_NEXT [47] = '{
      6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10,
      6'd11, 6'd12, 6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
      6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
      6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
      6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46};

   localparam logic [5:0] LPS_NEXT [47] = '{
      6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14,
      6'd17, 6'd18, 6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18,
      6'd19, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27,
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
      6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46};

   localparam logic FLIP_MPS [47] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

endpackage

// File: src/mqd_front.sv
// ----------------------------------------------------------------------------
// mqd_front: request intake of the MQ arithmetic decoder
// Accepts requests, classifies the mode, clamps the state index and holds
// them in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module mqd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [4:0]        req_context_label,
   input  logic [7:0]        req_byte_value,
   input  logic              req_load_mps,
   input  logic [5:0]        req_load_state,
   output mqd_pkg::link_type link,
   input  logic              item_pop
);
   import mqd_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   item_type   classified;
   logic       accept;

   always_comb begin
      unique case (req_mode)
         OP_LOAD:  classified.op = OP_LOAD;
         OP_PUSH:  classified.op = OP_PUSH;
         OP_START: classified.op = OP_START;
         default:  classified.op = OP_DECODE;
      endcase
      classified.label      = req_context_label;
      classified.byte_value = req_byte_value;
      classified.load_mps   = req_load_mps;
      classified.load_state = (req_load_state > LAST_STATE) ? LAST_STATE : req_load_state;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign accept     = req_valid && !req_stall;
   assign link.valid = (count_ff != 2'd0);
   assign link.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      case ({accept, item_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (accept)   wr_ptr_ff <= ~wr_ptr_ff;
         if (item_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) slot_ff[wr_ptr_ff] <= classified;
   end

endmodule

// File: src/mqd_back.sv
// ----------------------------------------------------------------------------
// mqd_back: execution side of the MQ arithmetic decoder
// Context memory, byte queue, INITDEC, decision with conditional exchange,
// and chunked renormalization with byte refill and marker handling.
// ----------------------------------------------------------------------------
module mqd_back (
   input  logic              clock,
   input  logic              reset,
   input  mqd_pkg::link_type link,
   output logic              item_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_decoded_bit,
   output logic              rsp_byte_underflow
);
   import mqd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_TAKE,
      ST_START_FILL,
      ST_DECIDE,
      ST_RENORM
   } state_type;

   state_type          state_ff, state_in;
   logic [15:0]        interval_ff, interval_in;
   logic [31:0]        code_ff, code_in;
   logic [3:0]         bc_ff, bc_in;
   logic [7:0]         last_ff, last_in;
   logic [4:0]         done_ff, done_in;
   logic               uf_ff, uf_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_bit_ff, rsp_bit_in;
   logic               rsp_uf_ff, rsp_uf_in;
   logic [CTX_W-1:0]   label_ff, label_in;
   logic               bit_ff, bit_in;

   logic [7:0]         bq_ff [QUEUE_DEPTH];
   logic [6:0]         ctx_mem [NUM_CONTEXTS];
   logic [6:0]         ctx_rd_ff;
   logic               ctx_rd_en, ctx_wr_en;
   logic [CTX_W-1:0]   ctx_wr_addr;
   logic [6:0]         ctx_wr_data;
   logic               q_push, q_pop;

   logic               q_empty;
   logic [7:0]         q_head;
   logic               bi_pop, bi_uf;
   logic [7:0]         bi_last;
   logic [31:0]        bi_add;
   logic [3:0]         bi_bc;

   logic               ctx_mps;
   logic [5:0]         st;
   logic [15:0]        q;
   logic [15:0]        chigh;
   logic [15:0]        iv;
   logic               renorm_go, lps_take, dec_bit;
   logic [15:0]        dec_interval, dec_code_hi;
   logic               new_mps;
   logic [5:0]         new_state;

   logic               rn_refill, rn_finish;
   logic [3:0]         rn_bc0;
   logic [31:0]        rn_code0;
   logic [4:0]         lz, rn_rem, rn_shift;
   logic               out_free;

   assign q_empty = (fill_ff == '0);
   assign q_head  = q_empty ? STUFF_BYTE : bq_ff[0];

   always_comb begin
      bi_uf = q_empty;
      if (last_ff == STUFF_BYTE) begin
         if (q_head > MARKER_MIN) begin
            bi_pop  = 1'b0;
            bi_last = last_ff;
            bi_add  = MARKER_ADD;
            bi_bc   = BITS_PLAIN;
         end else begin
            bi_pop  = 1'b1;
            bi_last = q_head;
            bi_add  = {15'd0, q_head, 9'd0};
            bi_bc   = BITS_STUFFED;
         end
      end else begin
         bi_pop  = !q_empty;
         bi_last = q_head;
         bi_add  = {16'd0, q_head, 8'd0};
         bi_bc   = BITS_PLAIN;
      end
   end

   always_comb begin
      ctx_mps = ctx_rd_ff[6];
      st      = (ctx_rd_ff[5:0] > LAST_STATE) ? LAST_STATE : ctx_rd_ff[5:0];
      q       = QE_TAB[st];
      chigh   = code_ff[31:16];
      iv      = interval_ff - q;
      if (chigh < q) begin
         renorm_go    = 1'b1;
         dec_interval = q;
         dec_code_hi  = chigh;
         lps_take     = !(iv < q);
      end else begin
         renorm_go    = !iv[15];
         dec_interval = iv;
         dec_code_hi  = chigh - q;
         lps_take     = !iv[15] && (iv < q);
      end
      dec_bit   = lps_take ? ~ctx_mps : ctx_mps;
      new_mps   = lps_take ? (ctx_mps ^ FLIP_MPS[st]) : ctx_mps;
      new_state = lps_take ? LPS_NEXT[st] : MPS_NEXT[st];
   end

   always_comb begin
      lz = MAX_SHIFTS;
      for (int i = 0; i < 16; i++) begin
         if (interval_ff[i]) lz = 5'(15 - i);
      end
   end

   always_comb begin
      rn_refill = (bc_ff == 4'd0);
      rn_bc0    = rn_refill ? bi_bc : bc_ff;
      rn_code0  = rn_refill ? (code_ff + bi_add) : code_ff;
      rn_rem    = (interval_ff == 16'd0) ? (MAX_SHIFTS - done_ff) : lz;
      rn_shift  = (rn_rem < {1'b0, rn_bc0}) ? rn_rem : {1'b0, rn_bc0};
      rn_finish = (rn_shift == rn_rem);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      code_in      = code_ff;
      bc_in        = bc_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      uf_in        = uf_ff;
      label_in     = label_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_bit_in   = rsp_bit_ff;
      rsp_uf_in    = rsp_uf_ff;
      item_pop     = 1'b0;
      q_push       = 1'b0;
      q_pop        = 1'b0;
      ctx_rd_en    = 1'b0;
      ctx_wr_en    = 1'b0;
      ctx_wr_addr  = label_ff;
      ctx_wr_data  = {new_mps, new_state};

      unique case (state_ff)
         ST_IDLE: begin
            if (link.valid) begin
               item_pop = 1'b1;
               uf_in    = 1'b0;
               unique case (link.item.op)
                  OP_LOAD: begin
                     ctx_wr_en   = 1'b1;
                     ctx_wr_addr = link.item.label[CTX_W-1:0];
                     ctx_wr_data = {link.item.load_mps, link.item.load_state};
                  end
                  OP_PUSH: begin
                     q_push = (fill_ff < FILL_W'(QUEUE_DEPTH));
                  end
                  OP_START: begin
                     state_in = ST_START_TAKE;
                  end
                  OP_DECODE: begin
                     ctx_rd_en = 1'b1;
                     label_in  = link.item.label[CTX_W-1:0];
                     state_in  = ST_DECIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_START_TAKE: begin
            q_pop    = !q_empty;
            last_in  = q_head;
            code_in  = {8'd0, q_head, 16'd0};
            uf_in    = q_empty;
            state_in = ST_START_FILL;
         end
         ST_START_FILL: begin
            if (out_free) begin
               q_pop        = bi_pop;
               last_in      = bi_last;
               code_in      = (code_ff + bi_add) << 7;
               bc_in        = bi_bc - BITS_STUFFED;
               interval_in  = INTERVAL_INIT;
               uf_in        = uf_ff | bi_uf;
               rsp_valid_in = 1'b1;
               rsp_bit_in   = 1'b0;
               rsp_uf_in    = uf_ff | bi_uf;
               state_in     = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            if (renorm_go || out_free) begin
               interval_in = dec_interval;
               code_in     = {dec_code_hi, code_ff[15:0]};
               bit_in      = dec_bit;
               done_in     = 5'd0;
               if (renorm_go) begin
                  ctx_wr_en = 1'b1;
                  state_in  = ST_RENORM;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_bit_in   = ctx_mps;
                  rsp_uf_in    = uf_ff;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_RENORM: begin
            if (!rn_finish || out_free) begin
               q_pop       = rn_refill && bi_pop;
               if (rn_refill) last_in = bi_last;
               uf_in       = uf_ff | (rn_refill && bi_uf);
               interval_in = 16'(interval_ff << rn_shift);
               code_in     = rn_code0 << rn_shift;
               bc_in       = rn_bc0 - rn_shift[3:0];
               done_in     = done_ff + rn_shift;
               if (rn_finish) begin
                  rsp_valid_in = 1'b1;
                  rsp_bit_in   = bit_ff;
                  rsp_uf_in    = uf_ff | (rn_refill && bi_uf);
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case ({q_push, q_pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= 16'd0;
         code_ff      <= 32'd0;
         bc_ff        <= 4'd0;
         last_ff      <= 8'd0;
         done_ff      <= 5'd0;
         uf_ff        <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_bit_ff   <= 1'b0;
         rsp_uf_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         code_ff      <= code_in;
         bc_ff        <= bc_in;
         last_ff      <= last_in;
         done_ff      <= done_in;
         uf_ff        <= uf_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_bit_ff   <= rsp_bit_in;
         rsp_uf_ff    <= rsp_uf_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff   <= label_in;
      bit_ff     <= bit_in;
   end

   always_ff @(posedge clock) begin
      if (q_push) bq_ff[fill_ff[QI_W-1:0]] <= link.item.byte_value;
      if (q_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) bq_ff[i] <= bq_ff[i + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctx_wr_en) ctx_mem[ctx_wr_addr] <= ctx_wr_data;
      if (ctx_rd_en) ctx_rd_ff <= ctx_mem[link.item.label[CTX_W-1:0]];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_decoded_bit    = rsp_bit_ff;
   assign rsp_byte_underflow = rsp_uf_ff;

endmodule

// File: src/mq_arithmetic_decoder.sv
// A request is taken into a two-entry queue; the execution side picks it up from there
// when idle. Load and push are carried out in the idle state; start passes through the
// take and fill states. Decode reads the context, then decides, then renormalizes where
// needed in chunks, each shifting up to the bits left in the current code byte before a refill.
// Reset clears interval, code, bit count, last byte and queues; contexts need a load.
// ----------------------------------------------------------------------------
// mq_arithmetic_decoder: MQ adaptive binary arithmetic decoder
// Request intake and queue in front, decoding engine with result register behind.
// ----------------------------------------------------------------------------
module mq_arithmetic_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [4:0] req_context_label,
   input  logic [7:0] req_byte_value,
   input  logic       req_load_mps,
   input  logic [5:0] req_load_state,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_decoded_bit,
   output logic       rsp_byte_underflow
);
   import mqd_pkg::*;

   link_type link;
   logic     item_pop;

   mqd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_context_label (req_context_label),
      .req_byte_value    (req_byte_value),
      .req_load_mps      (req_load_mps),
      .req_load_state    (req_load_state),
      .link              (link),
      .item_pop          (item_pop)
   );

   mqd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .link               (link),
      .item_pop           (item_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded_bit    (rsp_decoded_bit),
      .rsp_byte_underflow (rsp_byte_underflow)
   );

endmodule

// File: src/mqd_checker.sv
// ----------------------------------------------------------------------------
// mqd_checker: port-level checks of the MQ arithmetic decoder
// Watches request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module mqd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_decoded_bit,
   input logic       rsp_byte_underflow
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");

   a_stall_needs_request: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("request queue filled without an accepted request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_decoded_bit)
                                 && $stable(rsp_byte_underflow))
      else $error("stalled result changed");

   a_rsp_after_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset))
      else $error("result raised straight out of reset");

endmodule

bind mq_arithmetic_decoder mqd_checker u_mqd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_decoded_bit    (rsp_decoded_bit),
   .rsp_byte_underflow (rsp_byte_underflow)
);
